FILE: src/pixel_threshold_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// pixel_threshold_bit_packer_macros.svh
// assertion macros used by the packer checker
// ----------------------------------------------------------------------------
`ifndef PIXEL_THRESHOLD_BIT_PACKER_MACROS_SVH
`define PIXEL_THRESHOLD_BIT_PACKER_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define PTBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packer check failed");

// next-cycle implication, sampled on clk, off while reset is asserted
`define PTBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packer check failed");

`endif

FILE: src/ptbp_pkg.sv
// ----------------------------------------------------------------------------
// ptbp_pkg
// types and constants shared by the threshold bit packer modules
// ----------------------------------------------------------------------------
package ptbp_pkg;

	// pixel classification modes, code 3 acts as colour
	typedef enum logic [1:0] {
		MODE_BW     = 2'd0,
		MODE_GREY   = 2'd1,
		MODE_COLOUR = 2'd2
	} pixel_mode_t;

	// configuration register indexes
	localparam logic [1:0] CFG_IDX_MODE   = 2'd0;
	localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

	// dark thresholds: grey value and 2r+2g+b weighted sum
	localparam logic [7:0]  GREY_LIMIT   = 8'd128;
	localparam logic [10:0] COLOUR_LIMIT = 11'd640;

	localparam int unsigned BYTE_BITS = 8;

	// one input pixel, first channel in the low bits
	typedef struct packed {
		logic [7:0] pix_blue;
		logic [7:0] pix_green;
		logic [7:0] pix_first;
	} pix_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [1:0]  pixel_mode;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

	// classified item leaving the input register
	typedef struct packed {
		logic valid;
		logic dark;
	} item_t;

endpackage

FILE: src/ptbp_classify.sv
// ----------------------------------------------------------------------------
// ptbp_classify
// decides whether one registered pixel is dark under the current mode
// ----------------------------------------------------------------------------
module ptbp_classify (
	input  ptbp_pkg::pix_t       pix,
	input  logic [1:0]           pixel_mode,
	output logic                 dark
);
	import ptbp_pkg::*;

	logic [10:0] weighted;

	// 2r + 2g + b, at most 1275
	assign weighted = {2'b00, pix.pix_first, 1'b0} + {2'b00, pix.pix_green, 1'b0}
		+ {3'b000, pix.pix_blue};

	// threshold per mode
	always_comb begin
		case (pixel_mode)
			MODE_BW:   dark = (pix.pix_first == 8'd0);
			MODE_GREY: dark = (pix.pix_first <= GREY_LIMIT);
			default:   dark = (weighted <= COLOUR_LIMIT);
		endcase
	end

endmodule

FILE: src/ptbp_pack.sv
// ----------------------------------------------------------------------------
// ptbp_pack
// gathers dark bits into bytes, tracks row and column, holds the result beat
// ----------------------------------------------------------------------------
module ptbp_pack (
	input  logic             clk,
	input  logic             arst_n,
	input  ptbp_pkg::cfg_t   cfg,
	input  ptbp_pkg::item_t  item,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       packed_byte,
	output logic             row_end,
	output logic             image_end
);
	import ptbp_pkg::*;

	logic [7:0]  shift_q;
	logic [2:0]  count_q;
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        row_end_q;
	logic        image_end_q;

	logic [7:0]  byte_next;
	logic        last_col;
	logic        last_row;
	logic        emit;
	logic        fire;

	// result register free this cycle
	assign advance = !out_valid_q || out_ready;
	assign fire    = item.valid && advance;

	// next byte and row/column end tests
	always_comb begin
		byte_next = shift_q | (item.dark ? (8'd1 << count_q) : 8'd0);
		last_col  = ({1'b0, column_q} + 17'd1) >= {1'b0, cfg.image_width};
		last_row  = ({1'b0, row_q} + 17'd1) >= {1'b0, cfg.image_height};
		emit      = (count_q == 3'(BYTE_BITS - 1)) || last_col;
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			count_q  <= '0;
			column_q <= '0;
			row_q    <= '0;
		end else if (fire) begin
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				column_q <= column_q + 16'd1;
			end
			if (emit) begin
				shift_q <= '0;
				count_q <= '0;
			end else begin
				shift_q <= byte_next;
				count_q <= count_q + 3'd1;
			end
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			byte_q      <= byte_next;
			row_end_q   <= last_col;
			image_end_q <= last_col && last_row;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign row_end     = row_end_q;
	assign image_end   = image_end_q;

endmodule

FILE: src/pixel_threshold_bit_packer.sv
// ----------------------------------------------------------------------------
// pixel_threshold_bit_packer
// thresholds a raster pixel stream to one bit per pixel and packs bytes
// ----------------------------------------------------------------------------
// an input beat passes the input register, then the result register
// one pixel per cycle unless m_axis stalls; result register frees as the beat is taken
// a byte leaves every eighth pixel of a row and at each row end, right-aligned
// reset: arst_n clears the pipeline, counters and config registers (mode 0, width 1, height 1)
module pixel_threshold_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	// pixel input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pix_first[7:0], pix_green[15:8], pix_blue[23:16]
	// packed byte beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // packed_byte[7:0]
	output logic        m_axis_tlast,  // row_end
	output logic [0:0]  m_axis_tuser,  // image_end[0]
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import ptbp_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	pix_t        pix_s1;
	logic        dark;
	item_t       item;
	logic        advance;
	logic        image_end;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode   <= MODE_BW;
			cfg_q.image_width  <= 16'd1;
			cfg_q.image_height <= 16'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_MODE:   cfg_q.pixel_mode   <= cfg_data[1:0];
				CFG_IDX_WIDTH:  cfg_q.image_width  <= cfg_data;
				CFG_IDX_HEIGHT: cfg_q.image_height <= cfg_data;
				default:        ;
			endcase
		end
	end

	// input register
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pix_s1 <= pix_t'(s_axis_tdata);
		end
	end

	ptbp_classify u_classify (
		.pix        (pix_s1),
		.pixel_mode (cfg_q.pixel_mode),
		.dark       (dark)
	);

	assign item.valid = valid_s1;
	assign item.dark  = dark;

	ptbp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item        (item),
		.advance     (advance),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.packed_byte (m_axis_tdata),
		.row_end     (m_axis_tlast),
		.image_end   (image_end)
	);

	assign m_axis_tuser = image_end;

endmodule

FILE: src/ptbp_checker.sv
// ----------------------------------------------------------------------------
// ptbp_checker
// port-level checks on the threshold bit packer
// ----------------------------------------------------------------------------
`include "pixel_threshold_bit_packer_macros.svh"

module ptbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result beat keeps its payload
	`PTBP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

	// the image end byte always closes a row
	`PTBP_ASSERT_NOW(a_image_end_row, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

	// with no result pending the input side never stalls
	`PTBP_ASSERT_NOW(a_in_ready_idle, !m_axis_tvalid, s_axis_tready)

	// a taken result beat leaves room for the next pixel
	`PTBP_ASSERT_NOW(a_in_ready_drain, m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind pixel_threshold_bit_packer ptbp_checker u_ptbp_checker (.*);
